FILE: rtl/core/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Used by dq_cell and double_ended_queue; depends on nothing else.
package dq_pkg;

	localparam int DATA_W          = 32;
	localparam int ACTION_W        = 3;
	localparam int OCC_W           = 5;
	localparam int DEF_QUEUE_DEPTH = 16;

	// Action codes carried by each input word
	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_PEEK_FRONT = 3'd4,
		ACT_PEEK_BACK  = 3'd5
	} action_t;

	// Command broadcast to every cell of the row
	typedef enum logic [2:0] {
		CELL_HOLD      = 3'd0,
		CELL_SHIFT_UP  = 3'd1,
		CELL_SHIFT_DN  = 3'd2,
		CELL_APPEND    = 3'd3,
		CELL_DROP_TAIL = 3'd4
	} cell_cmd_t;

	// What a cell shows its neighbors
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] word;
	} dq_link_t;

endpackage

FILE: rtl/core/dq_cell.sv
// One storage cell of the queue row: a word and its valid bit.
// Depends on dq_pkg; instantiated in a row by double_ended_queue.
module dq_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dq_pkg::cell_cmd_t                cmd,
	input  logic signed [dq_pkg::DATA_W-1:0] push_word,
	input  dq_pkg::dq_link_t                 prev,
	input  dq_pkg::dq_link_t                 next,
	output dq_pkg::dq_link_t                 cur,
	output logic signed [dq_pkg::DATA_W-1:0] tail_word
);

	logic                             vld_q;
	logic signed [dq_pkg::DATA_W-1:0] word_q;
	logic                             vld_d;
	logic signed [dq_pkg::DATA_W-1:0] word_d;
	logic                             is_tail;

	// This cell holds the back word when it is valid and its upper neighbor is empty
	assign is_tail = vld_q && !next.vld;

	// Pick the next contents from the command and the neighbors
	always_comb begin
		vld_d  = vld_q;
		word_d = word_q;
		case (cmd)
			dq_pkg::CELL_SHIFT_UP: begin
				vld_d  = prev.vld;
				word_d = prev.word;
			end
			dq_pkg::CELL_SHIFT_DN: begin
				vld_d  = next.vld;
				word_d = next.word;
			end
			dq_pkg::CELL_APPEND: begin
				if (prev.vld && !vld_q) begin
					vld_d  = 1'b1;
					word_d = push_word;
				end
			end
			dq_pkg::CELL_DROP_TAIL: begin
				if (is_tail) begin
					vld_d = 1'b0;
				end
			end
			default: begin
				vld_d  = vld_q;
				word_d = word_q;
			end
		endcase
	end

	// Clear occupancy on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
		end
	end

	// Hold the word; no reset needed
	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign cur.vld   = vld_q;
	assign cur.word  = word_q;
	assign tail_word = is_tail ? word_q : '0;

endmodule

FILE: rtl/core/double_ended_queue.sv
// Bounded double-ended queue built from a row of shifting cells.
// Depends on dq_pkg and dq_cell.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid / in_stall    | action, data_in
//   out     | out_valid / out_stall  | data_out, occupancy, is_empty, op_error
//
// One word is taken per cycle while in_stall is low; its result is loaded into
// the output register on the next cycle. The rate rests on the cell row, which
// shifts, appends or drops as a whole, and on the OR tree that gathers the back word.
// Reset clears the cell valid bits, the count and the output valid; cell words
// are not cleared. No clearing pass is needed. in_stall is high only while a
// result waits in the output register and out_stall holds it.
module double_ended_queue #(
	parameter int QUEUE_DEPTH = dq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dq_pkg::ACTION_W-1:0]        action,
	input  logic signed [dq_pkg::DATA_W-1:0]   data_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dq_pkg::DATA_W-1:0]   data_out,
	output logic [dq_pkg::OCC_W-1:0]           occupancy,
	output logic                               is_empty,
	output logic                               op_error
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int OccW = dq_pkg::OCC_W;

	dq_pkg::dq_link_t                 link [QUEUE_DEPTH];
	logic signed [dq_pkg::DATA_W-1:0] tail_word [QUEUE_DEPTH];
	dq_pkg::dq_link_t                 cell0_prev;
	dq_pkg::dq_link_t                 top_next;
	dq_pkg::cell_cmd_t                cmd;

	logic [CntW-1:0]                  cnt_q;
	logic [CntW-1:0]                  cnt_d;
	logic                             accept;
	logic                             empty;
	logic                             full;
	logic signed [dq_pkg::DATA_W-1:0] back_word;
	logic signed [dq_pkg::DATA_W-1:0] result;
	logic                             err;

	logic                             out_valid_q;
	logic signed [dq_pkg::DATA_W-1:0] data_out_q;
	logic [OccW-1:0]                  occupancy_q;
	logic                             is_empty_q;
	logic                             op_error_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign empty    = !link[0].vld;
	assign full     = link[QUEUE_DEPTH-1].vld;

	// Feed the push word into the bottom; close the top with an empty slot
	assign cell0_prev.vld  = 1'b1;
	assign cell0_prev.word = data_in;
	assign top_next.vld    = 1'b0;
	assign top_next.word   = '0;

	// Build the row of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		dq_pkg::dq_link_t prev_l;
		dq_pkg::dq_link_t next_l;
		if (i == 0) begin : g_first
			assign prev_l = cell0_prev;
		end else begin : g_mid_lo
			assign prev_l = link[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_l = top_next;
		end else begin : g_mid_hi
			assign next_l = link[i+1];
		end
		dq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.push_word (data_in),
			.prev      (prev_l),
			.next      (next_l),
			.cur       (link[i]),
			.tail_word (tail_word[i])
		);
	end

	// Gather the back word from the single tail cell
	always_comb begin
		back_word = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			back_word = back_word | tail_word[i];
		end
	end

	// Decode the action into a row command, result, error flag and next count
	always_comb begin
		cmd    = dq_pkg::CELL_HOLD;
		cnt_d  = cnt_q;
		result = '0;
		err    = 1'b0;
		case (dq_pkg::action_t'(action))
			dq_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					err = 1'b1;
				end else begin
					cmd   = dq_pkg::CELL_SHIFT_UP;
					cnt_d = cnt_q + CntW'(1);
				end
			end
			dq_pkg::ACT_PUSH_BACK: begin
				if (full) begin
					err = 1'b1;
				end else begin
					cmd   = dq_pkg::CELL_APPEND;
					cnt_d = cnt_q + CntW'(1);
				end
			end
			dq_pkg::ACT_POP_FRONT: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					cmd    = dq_pkg::CELL_SHIFT_DN;
					cnt_d  = cnt_q - CntW'(1);
					result = link[0].word;
				end
			end
			dq_pkg::ACT_POP_BACK: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					cmd    = dq_pkg::CELL_DROP_TAIL;
					cnt_d  = cnt_q - CntW'(1);
					result = back_word;
				end
			end
			dq_pkg::ACT_PEEK_FRONT: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					result = link[0].word;
				end
			end
			dq_pkg::ACT_PEEK_BACK: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					result = back_word;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
		if (!accept) begin
			cmd   = dq_pkg::CELL_HOLD;
			cnt_d = cnt_q;
		end
	end

	// Advance the count and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result word and flags on accept, hold them otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q  <= result;
			occupancy_q <= OccW'(cnt_d);
			is_empty_q  <= (cnt_d == '0);
			op_error_q  <= err;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign occupancy = occupancy_q;
	assign is_empty  = is_empty_q;
	assign op_error  = op_error_q;

	// The count and the bottom cell agree on emptiness
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) == !link[0].vld)
		else $error("count and bottom cell disagree on empty");

	// The count and the top cell agree on fullness
	a_full_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CntW'(QUEUE_DEPTH)) == link[QUEUE_DEPTH-1].vld)
		else $error("count and top cell disagree on full");

	// A refused push leaves the count alone and flags the result
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && (action == dq_pkg::ACT_PUSH_FRONT ||
			action == dq_pkg::ACT_PUSH_BACK))
		|=> (op_error_q && out_valid_q && $stable(cnt_q)))
		else $error("push to full queue not refused");

	// A pop on an empty queue flags an error and returns zero
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && empty && (action == dq_pkg::ACT_POP_FRONT ||
			action == dq_pkg::ACT_POP_BACK))
		|=> (op_error_q && data_out_q == '0 && is_empty_q))
		else $error("pop on empty queue not flagged");

endmodule

FILE: test/double_ended_queue_tb.sv
// Self-checking testbench for double_ended_queue: directed table, then random walks.
// Depends on dq_pkg and the double_ended_queue RTL; predicts each result in-house.
`timescale 1ns / 100ps

module double_ended_queue_tb;

	localparam int DEPTH        = dq_pkg::DEF_QUEUE_DEPTH;
	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 617;

	// Codes outside the action set: the block must refuse them
	localparam logic [dq_pkg::ACTION_W-1:0] ACT_RSVD_A = 3'd6;
	localparam logic [dq_pkg::ACTION_W-1:0] ACT_RSVD_B = 3'd7;

	typedef struct packed {
		logic signed [dq_pkg::DATA_W-1:0] word;
		logic [dq_pkg::OCC_W-1:0]         occ;
		logic                             empty;
		logic                             err;
	} result_t;

	typedef struct packed {
		logic [dq_pkg::ACTION_W-1:0]      act;
		logic signed [dq_pkg::DATA_W-1:0] data;
		logic [4:0]                       reps;
		logic                             typed;
		result_t                          exp;
	} stim_row_t;

	typedef enum int {
		WALK_FILL,
		WALK_DRAIN,
		WALK_MIX
	} walk_mode_t;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic [dq_pkg::ACTION_W-1:0]      action;
	logic signed [dq_pkg::DATA_W-1:0] data_in;
	logic                             out_valid;
	logic                             out_stall;
	logic signed [dq_pkg::DATA_W-1:0] data_out;
	logic [dq_pkg::OCC_W-1:0]         occupancy;
	logic                             is_empty;
	logic                             op_error;

	// Predicted deque contents
	logic signed [dq_pkg::DATA_W-1:0] dq_words [DEPTH];
	int                               front_idx;
	int                               back_idx;
	int                               word_count;

	result_t   expected_results [$];
	stim_row_t dir_rows [$];
	logic      row_typed;
	result_t   row_exp;
	int        send_idle_pct;
	int        recv_stall_pct;
	bit        long_hold_due;
	int        fail_count;
	int        quiet_cycles;

	double_ended_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_out  (data_out),
		.occupancy (occupancy),
		.is_empty  (is_empty),
		.op_error  (op_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one action to the predicted deque and return its result
	function automatic result_t deque_apply(input logic [dq_pkg::ACTION_W-1:0] act,
			input logic signed [dq_pkg::DATA_W-1:0] word);
		result_t r;
		r = '0;
		case (act)
			dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
				if (word_count >= DEPTH) begin
					r.err = 1'b1;
				end else if (word_count == 0) begin
					dq_words[front_idx] = word;
					back_idx = front_idx;
					word_count = 1;
				end else if (act == dq_pkg::ACT_PUSH_FRONT) begin
					front_idx = (front_idx + DEPTH - 1) % DEPTH;
					dq_words[front_idx] = word;
					word_count++;
				end else begin
					back_idx = (back_idx + 1) % DEPTH;
					dq_words[back_idx] = word;
					word_count++;
				end
			end
			dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
				if (word_count == 0) begin
					r.err = 1'b1;
				end else begin
					r.word = (act == dq_pkg::ACT_POP_FRONT) ? dq_words[front_idx] :
						dq_words[back_idx];
					word_count--;
					if (word_count == 0)
						back_idx = front_idx;
					else if (act == dq_pkg::ACT_POP_FRONT)
						front_idx = (front_idx + 1) % DEPTH;
					else
						back_idx = (back_idx + DEPTH - 1) % DEPTH;
				end
			end
			dq_pkg::ACT_PEEK_FRONT, dq_pkg::ACT_PEEK_BACK: begin
				if (word_count == 0)
					r.err = 1'b1;
				else
					r.word = (act == dq_pkg::ACT_PEEK_FRONT) ? dq_words[front_idx] :
						dq_words[back_idx];
			end
			default: begin
				r.err = 1'b1;
			end
		endcase
		r.occ = 5'(word_count);
		r.empty = (word_count == 0);
		return r;
	endfunction

	// Random word, leaning toward the extremes
	function automatic logic signed [dq_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Random action; the walk mode biases toward pushes or pops
	function automatic logic [dq_pkg::ACTION_W-1:0] pick_action(input walk_mode_t mode);
		int r;
		int push_pct;
		r = $urandom_range(0, 99);
		push_pct = (mode == WALK_FILL) ? 75 : (mode == WALK_DRAIN) ? 20 : 45;
		if (r < 2)
			return ACT_RSVD_A;
		if (r < 4)
			return ACT_RSVD_B;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_BACK;
		case ($urandom_range(0, 3))
			0: return dq_pkg::ACT_POP_FRONT;
			1: return dq_pkg::ACT_POP_BACK;
			2: return dq_pkg::ACT_PEEK_FRONT;
			default: return dq_pkg::ACT_PEEK_BACK;
		endcase
	endfunction

	task automatic add_row(input logic [dq_pkg::ACTION_W-1:0] act,
			input logic signed [dq_pkg::DATA_W-1:0] data,
			input int reps, input logic typed, input logic signed [dq_pkg::DATA_W-1:0] w,
			input int occ, input logic empty, input logic err);
		stim_row_t row;
		row.act = act;
		row.data = data;
		row.reps = 5'(reps);
		row.typed = typed;
		row.exp = '{word: w, occ: 5'(occ), empty: empty, err: err};
		dir_rows.push_back(row);
	endtask

	// Offer one word at the falling edge and hold it until accepted
	task automatic send_word(input logic [dq_pkg::ACTION_W-1:0] act,
			input logic signed [dq_pkg::DATA_W-1:0] data,
			input logic typed, input result_t exp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		data_in   <= data;
		row_typed <= typed;
		row_exp   <= exp;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Receiver: random stall, plus one long hold-off to back up the input
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Check results, predict accepted words, and watch for a hang
	always @(posedge clk) begin
		result_t got;
		result_t want;
		result_t guess;
		bit      moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = {data_out, occupancy, is_empty, op_error};
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result word=%0d occ=%0d empty=%b err=%b",
						$time, got.word, got.occ, got.empty, got.err);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_count++;
						$display({"%0t: mismatch expected word=%0d occ=%0d empty=%b err=%b",
							" actual word=%0d occ=%0d empty=%b err=%b"}, $time,
							want.word, want.occ, want.empty, want.err,
							got.word, got.occ, got.empty, got.err);
					end
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				guess = deque_apply(action, data_in);
				expected_results.push_back(row_typed ? row_exp : guess);
			end
			if (moved)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		walk_mode_t mode;
		int         mode_left;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = dq_pkg::ACT_PUSH_FRONT;
		data_in        = '0;
		row_typed      = 1'b0;
		row_exp        = '0;
		send_idle_pct  = 14;
		recv_stall_pct = 69;
		long_hold_due  = 1'b0;
		fail_count     = 0;
		quiet_cycles   = 0;
		front_idx      = 0;
		back_idx       = 0;
		word_count     = 0;
		mode           = WALK_MIX;
		mode_left      = 0;

		// Empty queue: every read and every unknown code is refused
		add_row(dq_pkg::ACT_POP_FRONT,  32'sd0, 1, 1, 0, 0, 1, 1);
		add_row(dq_pkg::ACT_POP_BACK,   32'sd0, 1, 1, 0, 0, 1, 1);
		add_row(dq_pkg::ACT_PEEK_FRONT, 32'sd0, 1, 1, 0, 0, 1, 1);
		add_row(dq_pkg::ACT_PEEK_BACK,  32'sd0, 1, 1, 0, 0, 1, 1);
		add_row(ACT_RSVD_A, 32'sh1234_5678, 1, 1, 0, 0, 1, 1);
		add_row(ACT_RSVD_B, -32'sd1,        1, 1, 0, 0, 1, 1);
		// Extremes at both ends, then pop the last word
		add_row(dq_pkg::ACT_PUSH_BACK,  32'sh7FFF_FFFF, 1, 1, 0, 1, 0, 0);
		add_row(dq_pkg::ACT_PEEK_FRONT, 32'sd0, 1, 1, 32'sh7FFF_FFFF, 1, 0, 0);
		add_row(dq_pkg::ACT_PUSH_FRONT, 32'sh8000_0000, 1, 1, 0, 2, 0, 0);
		add_row(dq_pkg::ACT_PEEK_FRONT, 32'sd0, 1, 0, 0, 0, 0, 0);
		add_row(dq_pkg::ACT_PEEK_BACK,  32'sd0, 1, 0, 0, 0, 0, 0);
		add_row(ACT_RSVD_B,             32'sd5, 1, 0, 0, 0, 0, 0);
		add_row(dq_pkg::ACT_POP_BACK,   32'sd0, 1, 0, 0, 0, 0, 0);
		add_row(dq_pkg::ACT_POP_FRONT,  32'sd0, 1, 1, 32'sh8000_0000, 0, 1, 0);
		// Push into empty, fill to the brim, push on full at both ends, then peek, pop and push at the brim
		add_row(dq_pkg::ACT_PUSH_FRONT, 32'sd0, 1, 1, 0, 1, 0, 0);
		add_row(dq_pkg::ACT_PUSH_BACK,  -32'sd1, 15, 0, 0, 0, 0, 0);
		add_row(dq_pkg::ACT_PUSH_FRONT, 32'sh55AA_55AA, 1, 1, 0, 16, 0, 1);
		add_row(dq_pkg::ACT_PUSH_BACK,  32'sh55AA_55AA, 1, 1, 0, 16, 0, 1);
		add_row(dq_pkg::ACT_PEEK_BACK,  32'sd0, 1, 0, 0, 0, 0, 0);
		add_row(dq_pkg::ACT_POP_FRONT,  32'sd0, 1, 0, 0, 0, 0, 0);
		add_row(dq_pkg::ACT_PUSH_FRONT, 32'sh0F0F_0F0F, 1, 0, 0, 0, 0, 0);
		add_row(dq_pkg::ACT_POP_BACK,   32'sd0, 1, 0, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++)
				send_word(dir_rows[i].act, dir_rows[i].data ^ k, dir_rows[i].typed,
					dir_rows[i].exp);
		end

		// Random walks: receiver stalls, then sender idles, then neither but one long receiver hold
		for (int p = 0; p < 3; p++) begin
			send_idle_pct  = (p == 0) ? 14 : (p == 1) ? 69 : 0;
			recv_stall_pct = (p == 0) ? 69 : (p == 1) ? 14 : 0;
			if (p == 2)
				long_hold_due = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (mode_left == 0) begin
					mode = walk_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(6, 40);
				end
				mode_left--;
				send_word(pick_action(mode), pick_word(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue.sv
test/double_ended_queue_tb.sv
